/* rtl/jse_pkg.sv */
// Shared types, constants and helper functions of the JSON string escaper.
`default_nettype none
package jse_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_VAL  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_VAL  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_VAL  = 8'hF0;

    localparam logic [20:0] SUPP_BASE = 21'h10000;
    localparam logic [5:0]  SURR_HI   = 6'b110110;  // 0xD800 >> 10
    localparam logic [5:0]  SURR_LO   = 6'b110111;  // 0xDC00 >> 10
    localparam logic [7:0]  STRAY_HI  = 8'hDC;

    typedef enum logic [1:0] {
        KIND_PLAIN = 2'd0,
        KIND_ESC   = 2'd1,
        KIND_UNI1  = 2'd2,
        KIND_UNI2  = 2'd3
    } t_kind;

    // One unit of output work: a raw byte, a two-byte escape, or one or two \uXXXX.
    typedef struct packed {
        t_kind       kind;
        logic [15:0] word0;
        logic [15:0] word1;
    } t_job;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = 8'h30 + {4'd0, nib};
        end else begin
            r = 8'h57 + {4'd0, nib};
        end
        return r;
    endfunction

    function automatic logic [7:0] esc_letter(input logic [6:0] c);
        logic [7:0] r;
        case (c)
            7'h22:   r = 8'h22;
            7'h08:   r = 8'h62;
            7'h0C:   r = 8'h66;
            7'h0A:   r = 8'h6E;
            7'h0D:   r = 8'h72;
            7'h09:   r = 8'h74;
            7'h0B:   r = 8'h76;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] job_len(input t_kind k);
        logic [3:0] r;
        case (k)
            KIND_PLAIN: r = 4'd1;
            KIND_ESC:   r = 4'd2;
            KIND_UNI1:  r = 4'd6;
            KIND_UNI2:  r = 4'd12;
            default:    r = 4'd1;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/jse_front.sv */
// Front end: takes input bytes, gathers UTF-8 sequences and issues output jobs.
`default_nettype none
module jse_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_string_end,
    input  wire logic          i_cfg_valid,
    input  wire logic          i_cfg_escape_unicode,
    input  wire logic          i_queue_full,
    output logic               o_push,
    output jse_pkg::t_job      o_job
);
    import jse_pkg::*;

    logic          r_escape_unicode;
    logic [1:0]    r_pending;
    logic [1:0]    n_pending;
    logic [20:0]   r_accum;
    logic [20:0]   n_accum;
    logic          accept;
    logic [20:0]   gathered;
    logic [20:0]   supp;
    logic [7:0]    letter;

    assign o_in_ready = !i_queue_full;
    assign accept     = i_in_valid && o_in_ready;
    assign gathered   = {r_accum[14:0], i_data_byte[5:0]};
    assign supp       = gathered - SUPP_BASE;
    assign letter     = esc_letter(i_data_byte[6:0]);

    always_comb begin
        n_pending   = r_pending;
        n_accum     = r_accum;
        o_push      = 1'b0;
        o_job.kind  = KIND_PLAIN;
        o_job.word0 = {8'd0, i_data_byte};
        o_job.word1 = '0;
        if (r_pending != 2'd0) begin
            n_pending = r_pending - 2'd1;
            n_accum   = gathered;
            if (r_pending == 2'd1) begin
                n_accum = '0;
                o_push  = 1'b1;
                if (gathered[20:16] == 5'd0) begin
                    o_job.kind  = KIND_UNI1;
                    o_job.word0 = gathered[15:0];
                end else begin
                    o_job.kind  = KIND_UNI2;
                    o_job.word0 = {SURR_HI, supp[19:10]};
                    o_job.word1 = {SURR_LO, supp[9:0]};
                end
            end
        end else if (!i_data_byte[7]) begin
            o_push = 1'b1;
            if (letter != 8'd0) begin
                o_job.kind  = KIND_ESC;
                o_job.word0 = {8'd0, letter};
            end
        end else if (r_escape_unicode) begin
            if ((i_data_byte & LEAD2_MASK) == LEAD2_VAL) begin
                n_accum   = {16'd0, i_data_byte[4:0]};
                n_pending = 2'd1;
            end else if ((i_data_byte & LEAD3_MASK) == LEAD3_VAL) begin
                n_accum   = {17'd0, i_data_byte[3:0]};
                n_pending = 2'd2;
            end else if ((i_data_byte & LEAD4_MASK) == LEAD4_VAL) begin
                n_accum   = {18'd0, i_data_byte[2:0]};
                n_pending = 2'd3;
            end else begin
                o_push      = 1'b1;
                o_job.kind  = KIND_UNI1;
                o_job.word0 = {STRAY_HI, i_data_byte};
            end
        end else begin
            o_push = 1'b1;
        end
        if (i_string_end) begin
            n_pending = 2'd0;
            n_accum   = '0;
        end
        if (!accept) begin
            n_pending = r_pending;
            n_accum   = r_accum;
            o_push    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_unicode <= 1'b1;
            r_pending        <= 2'd0;
            r_accum          <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_escape_unicode <= i_cfg_escape_unicode;
            end
            r_pending <= n_pending;
            r_accum   <= n_accum;
        end
    end

endmodule
`default_nettype wire

/* rtl/jse_queue.sv */
// Small job queue in flip-flops between the front end and the serializer.
`default_nettype none
module jse_queue #(
    parameter int DEPTH = jse_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire jse_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_head_valid,
    output jse_pkg::t_job      o_head
);
    import jse_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_pop;

    assign o_full       = (r_count == FULL_CNT);
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/jse_back.sv */
// Back end: serializes one queued job into output bytes, one byte per cycle unless the output stalls.
`default_nettype none
module jse_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_head_valid,
    input  wire jse_pkg::t_job i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [7:0]         o_out_byte,
    output logic               o_last_of_run
);
    import jse_pkg::*;

    logic [3:0]  r_idx;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_last;
    logic        advance;
    logic        is_last;
    logic [7:0]  sel_byte;
    logic [2:0]  pos;
    logic [15:0] word;
    logic [3:0]  nib;

    assign advance = i_head_valid && (!r_out_valid || i_out_ready);
    assign is_last = (r_idx == job_len(i_head.kind) - 4'd1);
    assign o_pop   = advance && is_last;

    // Position within one \uXXXX group and the code unit it spells.
    always_comb begin
        if (r_idx < 4'd6) begin
            pos  = r_idx[2:0];
            word = i_head.word0;
        end else begin
            pos  = 3'(r_idx - 4'd6);
            word = i_head.word1;
        end
        case (pos)
            3'd2:    nib = word[15:12];
            3'd3:    nib = word[11:8];
            3'd4:    nib = word[7:4];
            default: nib = word[3:0];
        endcase
    end

    always_comb begin
        case (i_head.kind)
            KIND_PLAIN: sel_byte = i_head.word0[7:0];
            KIND_ESC:   sel_byte = (r_idx == 4'd0) ? CH_BSLASH : i_head.word0[7:0];
            default: begin
                if (pos == 3'd0) begin
                    sel_byte = CH_BSLASH;
                end else if (pos == 3'd1) begin
                    sel_byte = CH_U;
                end else begin
                    sel_byte = hex_char(nib);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= sel_byte;
            r_last     <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_idx       <= is_last ? 4'd0 : r_idx + 4'd1;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_last;

endmodule
`default_nettype wire

/* rtl/json_string_escaper.sv */
// JSON string body escaper: one input byte per cycle while the job queue has room, and
// escaped text out one byte per cycle unless the output stalls. A pushed job is stored
// in the job queue and then its first byte in the output register, which raises o_out_valid.
// Throughput: one input byte per cycle while the four-entry job queue has room; a job then
// is serialized into 1, 2, 6 or 12 output bytes, and a full queue stalls the input.
// Reset (synchronous, active low) closes any open UTF-8 sequence, empties the queue and
// the output register, and turns Unicode escaping on.
`default_nettype none
module json_string_escaper #(
    parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_string_end,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_run,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic       i_cfg_escape_unicode
);
    import jse_pkg::*;

    logic queue_full;
    logic push;
    t_job push_job;
    logic pop;
    logic head_valid;
    t_job head_job;

    assign o_cfg_ready = 1'b1;

    jse_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_data_byte          (i_data_byte),
        .i_string_end         (i_string_end),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_escape_unicode (i_cfg_escape_unicode),
        .i_queue_full         (queue_full),
        .o_push               (push),
        .o_job                (push_job)
    );

    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (push_job),
        .o_full       (queue_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head_job)
    );

    jse_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (head_valid),
        .i_head        (head_job),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule
`default_nettype wire
